>>> sv/hvl_pkg.sv
// shared constants, types and helper functions of the heading vector low-pass
`default_nettype none

package hvl_pkg;

  localparam int unsigned AngleFracBits = 6;
  localparam int unsigned HeadW         = 15;
  localparam int unsigned TdataW        = 16;
  localparam int unsigned FullTurn      = 360 << AngleFracBits;
  localparam int unsigned HalfTurn      = 180 << AngleFracBits;
  localparam int unsigned QuarterTurn   = 90 << AngleFracBits;
  localparam int unsigned MagW          = $clog2(QuarterTurn + 1);

  localparam int unsigned GainW     = 16;
  localparam int unsigned GainReset = 6554;

  localparam int unsigned SumW     = 18;
  localparam int unsigned OneQ16   = 65536;
  localparam int unsigned WideW    = 21;
  localparam int unsigned Q16Shift = 14;
  localparam int unsigned RoundQ16 = 1 << (Q16Shift - 1);
  localparam int unsigned LpShift  = 16;

  localparam int unsigned CordW     = 34;
  localparam int unsigned TableLen  = 24;
  localparam int unsigned TableIdxW = $clog2(TableLen);
  localparam int unsigned AtanW     = 32;

  localparam longint GainCorrQ30  = 652032874;
  localparam longint RadQ30PerDeg = 18740330;
  localparam longint RadHalf      = RadQ30PerDeg / 2;
  localparam int unsigned RadW    = 25;

  localparam int unsigned MulAW = RadW;
  localparam int unsigned MulBW = SumW + 1;
  localparam int unsigned ProdW = MulAW + 1 + MulBW;

  localparam int unsigned QuoW     = 14;
  localparam int unsigned DivW     = RadW + QuoW - 1;
  localparam int unsigned DivSteps = 4;
  localparam int unsigned DcntW    = $clog2(DivSteps);
  localparam int unsigned RW       = HeadW + 2;

  // reciprocal of radians per degree, estimate lands at most one below the quotient
  localparam int unsigned DivHiShift = 18;
  localparam int unsigned RecipShift = 20;
  localparam longint      RecipK     =
    (longint'(1) << (DivHiShift + RecipShift)) / RadQ30PerDeg;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_sts_t;

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_FOLD = 15'h0002,
    S_MULV = 15'h0004,
    S_ZSET = 15'h0008,
    S_ROT  = 15'h0010,
    S_VOUT = 15'h0020,
    S_MULE = 15'h0040,
    S_SUME = 15'h0080,
    S_MULN = 15'h0100,
    S_SUMN = 15'h0200,
    S_VSET = 15'h0400,
    S_VEC  = 15'h0800,
    S_DSET = 15'h1000,
    S_DIV  = 15'h2000,
    S_WRAP = 15'h4000
  } state_e;

  // arctangent of 2^-i in radians q2.30
  function automatic logic [AtanW-1:0] atan_q30(input logic [TableIdxW-1:0] idx);
    logic [AtanW-1:0] v;
    case (idx)
      5'd0:    v = 32'h3243F6A8;
      5'd1:    v = 32'h1DAC6705;
      5'd2:    v = 32'h0FADBAFC;
      5'd3:    v = 32'h07F56EA6;
      5'd4:    v = 32'h03FEAB76;
      5'd5:    v = 32'h01FFD55B;
      5'd6:    v = 32'h00FFFAAA;
      5'd7:    v = 32'h007FFF55;
      5'd8:    v = 32'h003FFFEA;
      5'd9:    v = 32'h001FFFFD;
      5'd10:   v = 32'h000FFFFF;
      5'd11:   v = 32'h0007FFFF;
      5'd12:   v = 32'h0003FFFF;
      5'd13:   v = 32'h0001FFFF;
      5'd14:   v = 32'h0000FFFF;
      5'd15:   v = 32'h00007FFF;
      5'd16:   v = 32'h00003FFF;
      5'd17:   v = 32'h00001FFF;
      5'd18:   v = 32'h00000FFF;
      5'd19:   v = 32'h000007FF;
      5'd20:   v = 32'h000003FF;
      5'd21:   v = 32'h000001FF;
      5'd22:   v = 32'h000000FF;
      5'd23:   v = 32'h0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [SumW-1:0] sat_q16(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] lim;
    logic signed [SumW-1:0] r;
    lim = WideW'(OneQ16);
    if (v > lim) begin
      r = SumW'(lim);
    end else if (v < -lim) begin
      r = SumW'(-lim);
    end else begin
      r = SumW'(v);
    end
    return r;
  endfunction

  // q4.30 to q2.16 with rounding and saturation
  function automatic logic signed [SumW-1:0] q30_to_q16(input logic signed [CordW-1:0] v);
    logic signed [CordW:0] t;
    t = (CordW+1)'(v) + $signed((CordW+1)'(RoundQ16));
    return sat_q16(WideW'(t >>> Q16Shift));
  endfunction

endpackage

`default_nettype wire

>>> sv/heading_vector_lowpass_core.sv
// Heading low-pass over the circle: each track beat (1/64 degree) is turned into a
// unit vector by a rotation-mode cordic, both components pass a first-order low-pass
// weighted by the gain register, and the smoothed vector goes back to a bearing by a
// vectoring-mode cordic and a reciprocal multiply, one result beat per input beat.
// Between one accept and the next an item makes two passes through the one shared
// cordic unit and uses one multiplier five times; when both sums are zero the
// vectoring pass and divide are skipped.
// The input is not ready while an item is in flight; a finished result waits in the
// output register and holds up the next item only if it is still there at the end.
`default_nettype none

module heading_vector_lowpass_core import hvl_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [GainW-1:0]  cfg_wdata_i,   // smoothing_gain
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [TdataW-1:0] s_axis_tdata,  // [14:0] heading_in
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TdataW-1:0] m_axis_tdata   // [14:0] filtered_heading
);

  localparam int unsigned NumSteps = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;

  localparam logic signed [HeadW:0]  FullS    = (HeadW+1)'(FullTurn);
  localparam logic signed [HeadW:0]  HalfS    = (HeadW+1)'(HalfTurn);
  localparam logic signed [HeadW:0]  QuarterS = (HeadW+1)'(QuarterTurn);
  localparam logic signed [RW-1:0]   FullR    = RW'(FullTurn);
  localparam logic signed [RW-1:0]   HalfR    = RW'(HalfTurn);
  localparam logic signed [SumW-1:0] SumLim   = SumW'(OneQ16);
  localparam logic [DcntW-1:0]       DivEstStep = DcntW'(1);
  localparam logic [DcntW-1:0]       DivFixStep = DcntW'(3);

  state_e state_q, state_d;

  logic [GainW-1:0] gain_q, gain_d;
  logic signed [SumW-1:0] east_sum_q, east_sum_d, north_sum_q, north_sum_d;
  logic out_valid_q, out_valid_d;
  logic [HeadW-1:0] out_head_q, out_head_d;

  logic [HeadW-1:0] a_q, a_d;
  logic flip_q, flip_d, neg_q, neg_d, base_q, base_d, zero_q, zero_d;
  logic [MulAW-1:0] mul_a_q, mul_a_d;
  logic signed [MulBW-1:0] mul_b_q, mul_b_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [SumW-1:0] comp_n_q, comp_n_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [QuoW-1:0] quo_q, quo_d;
  logic [DcntW-1:0] dcnt_q, dcnt_d;

  cordic_ctrl_t cor_ctrl;
  cordic_sts_t  cor_sts;
  logic signed [CordW-1:0] cor_x_in, cor_y_in, cor_z_in, cor_x, cor_y, cor_z;

  logic in_beat, out_load;
  logic [HeadW-1:0] head_in;
  logic signed [HeadW:0] ang_w, ang_f;
  logic fold_flip;
  logic [MagW-1:0] ang_mag;
  logic signed [CordW-1:0] zmag, xv, yv, zabs;
  logic signed [SumW-1:0] e_raw, n_raw, comp_e;
  logic signed [WideW-1:0] lp_step;
  logic [DivW-1:0] div_num, div_rem;
  logic [QuoW-1:0] quo_est;
  logic div_ge;
  logic signed [RW-1:0] q_s, r_w;

  hvl_cordic #(
    .NUM_STEPS(NumSteps)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cor_ctrl),
    .x_i    (cor_x_in),
    .y_i    (cor_y_in),
    .z_i    (cor_z_in),
    .sts_o  (cor_sts),
    .x_o    (cor_x),
    .y_o    (cor_y),
    .z_o    (cor_z)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign head_in       = s_axis_tdata[HeadW-1:0];
  assign out_load      = (state_q == S_WRAP) && (!out_valid_q || m_axis_tready);

  // shared multiplier
  assign prod_d = $signed({1'b0, mul_a_q}) * mul_b_q;

  // quadrant fold of the incoming angle
  always_comb begin
    ang_w = $signed({1'b0, a_q});
    if (a_q >= HeadW'(HalfTurn)) begin
      ang_w = ang_w - FullS;
    end
    ang_f     = ang_w;
    fold_flip = 1'b0;
    if (ang_w > QuarterS) begin
      ang_f     = ang_w - HalfS;
      fold_flip = 1'b1;
    end else if (ang_w < -QuarterS) begin
      ang_f     = ang_w + HalfS;
      fold_flip = 1'b1;
    end
    ang_mag = ang_f[HeadW] ? MagW'(-ang_f) : MagW'(ang_f);
  end

  assign zmag    = CordW'(prod_q >>> AngleFracBits);
  assign e_raw   = q30_to_q16(cor_y);
  assign n_raw   = q30_to_q16(cor_x);
  assign comp_e  = flip_q ? -e_raw : e_raw;
  assign lp_step = WideW'(prod_q >>> LpShift);
  assign xv      = CordW'(north_sum_q) <<< Q16Shift;
  assign yv      = CordW'(east_sum_q) <<< Q16Shift;
  assign zabs    = cor_z[CordW-1] ? -cor_z : cor_z;

  // degrees from radians: reciprocal estimate, then one compare and subtract
  assign div_num = (DivW'($unsigned(zabs)) << AngleFracBits) + DivW'(RadHalf);
  assign quo_est = QuoW'(prod_q >>> RecipShift);
  assign div_rem = rem_q - DivW'($unsigned(prod_q));
  assign div_ge  = (div_rem >= DivW'(RadQ30PerDeg));

  // bearing wrap
  always_comb begin
    q_s = $signed(RW'(quo_q));
    if (neg_q) begin
      q_s = -q_s;
    end
    r_w = (base_q ? HalfR : '0) + q_s;
    if (r_w < 0) begin
      r_w = r_w + FullR;
    end else if (r_w >= FullR) begin
      r_w = r_w - FullR;
    end
  end

  always_comb begin
    state_d     = state_q;
    gain_d      = gain_q;
    east_sum_d  = east_sum_q;
    north_sum_d = north_sum_q;
    out_valid_d = out_valid_q;
    out_head_d  = out_head_q;
    a_d         = a_q;
    flip_d      = flip_q;
    neg_d       = neg_q;
    base_d      = base_q;
    zero_d      = zero_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    comp_n_d    = comp_n_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dcnt_d      = dcnt_q;
    cor_ctrl    = '0;
    cor_x_in    = CordW'(GainCorrQ30);
    cor_y_in    = '0;
    cor_z_in    = '0;

    if (cfg_we_i) begin
      gain_d = cfg_wdata_i;
    end

    if (out_load) begin
      out_valid_d = 1'b1;
      out_head_d  = zero_q ? HeadW'(QuarterTurn) : HeadW'(r_w);
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          a_d     = (head_in >= HeadW'(FullTurn)) ? head_in - HeadW'(FullTurn) : head_in;
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        flip_d  = fold_flip;
        neg_d   = ang_f[HeadW];
        mul_a_d = MulAW'(RadQ30PerDeg);
        mul_b_d = $signed(MulBW'(ang_mag));
        state_d = S_MULV;
      end
      S_MULV: begin
        state_d = S_ZSET;
      end
      S_ZSET: begin
        cor_ctrl.start     = 1'b1;
        cor_ctrl.vectoring = 1'b0;
        cor_x_in           = CordW'(GainCorrQ30);
        cor_y_in           = '0;
        cor_z_in           = neg_q ? -zmag : zmag;
        state_d            = S_ROT;
      end
      S_ROT: begin
        if (cor_sts.done) begin
          state_d = S_VOUT;
        end
      end
      S_VOUT: begin
        comp_n_d = flip_q ? -n_raw : n_raw;
        mul_a_d  = MulAW'(gain_q);
        mul_b_d  = MulBW'(comp_e) - MulBW'(east_sum_q);
        state_d  = S_MULE;
      end
      S_MULE: begin
        state_d = S_SUME;
      end
      S_SUME: begin
        east_sum_d = sat_q16(WideW'(east_sum_q) + lp_step);
        mul_b_d    = MulBW'(comp_n_q) - MulBW'(north_sum_q);
        state_d    = S_MULN;
      end
      S_MULN: begin
        state_d = S_SUMN;
      end
      S_SUMN: begin
        north_sum_d = sat_q16(WideW'(north_sum_q) + lp_step);
        state_d     = S_VSET;
      end
      S_VSET: begin
        zero_d = (east_sum_q == '0) && (north_sum_q == '0);
        base_d = north_sum_q[SumW-1];
        if ((east_sum_q == '0) && (north_sum_q == '0)) begin
          state_d = S_WRAP;
        end else begin
          cor_ctrl.start     = 1'b1;
          cor_ctrl.vectoring = 1'b1;
          cor_x_in           = north_sum_q[SumW-1] ? -xv : xv;
          cor_y_in           = north_sum_q[SumW-1] ? -yv : yv;
          cor_z_in           = '0;
          state_d            = S_VEC;
        end
      end
      S_VEC: begin
        if (cor_sts.done) begin
          state_d = S_DSET;
        end
      end
      S_DSET: begin
        neg_d   = cor_z[CordW-1];
        rem_d   = div_num;
        mul_a_d = MulAW'(div_num >> DivHiShift);
        mul_b_d = MulBW'(RecipK);
        quo_d   = '0;
        dcnt_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DivEstStep) begin
          quo_d   = quo_est;
          mul_a_d = MulAW'(RadQ30PerDeg);
          mul_b_d = $signed(MulBW'(quo_est));
        end else if (dcnt_q == DivFixStep) begin
          quo_d   = quo_q + QuoW'(div_ge);
          state_d = S_WRAP;
        end
      end
      S_WRAP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gain_q      <= GainW'(GainReset);
      east_sum_q  <= '0;
      north_sum_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gain_q      <= gain_d;
      east_sum_q  <= east_sum_d;
      north_sum_q <= north_sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_head_q <= out_head_d;
    a_q        <= a_d;
    flip_q     <= flip_d;
    neg_q      <= neg_d;
    base_q     <= base_d;
    zero_q     <= zero_d;
    mul_a_q    <= mul_a_d;
    mul_b_q    <= mul_b_d;
    prod_q     <= prod_d;
    comp_n_q   <= comp_n_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    dcnt_q     <= dcnt_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(TdataW - HeadW){1'b0}}, out_head_q};

  a_ready_cordic_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !cor_sts.busy)
    else $error("input ready while cordic busy");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready)
    else $error("second beat accepted while item in flight");

  a_sums_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (east_sum_q <= SumLim) && (east_sum_q >= -SumLim) &&
    (north_sum_q <= SumLim) && (north_sum_q >= -SumLim))
    else $error("filter sum out of range");

  a_bearing_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_head_q < HeadW'(FullTurn)))
    else $error("bearing not wrapped");

endmodule

`default_nettype wire

>>> sv/hvl_cordic.sv
// iterative cordic unit, one micro-rotation per cycle, rotation or vectoring mode
`default_nettype none

module hvl_cordic import hvl_pkg::*; #(
  parameter int unsigned NUM_STEPS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cordic_ctrl_t            ctrl_i,
  input  logic signed [CordW-1:0] x_i,
  input  logic signed [CordW-1:0] y_i,
  input  logic signed [CordW-1:0] z_i,
  output cordic_sts_t             sts_o,
  output logic signed [CordW-1:0] x_o,
  output logic signed [CordW-1:0] y_o,
  output logic signed [CordW-1:0] z_o
);

  localparam int unsigned StepW = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;

  logic signed [CordW-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d, vect_q, vect_d;
  logic signed [CordW-1:0] dx, dy, at;
  logic sub_x;

  assign dx    = y_q >>> cnt_q;
  assign dy    = x_q >>> cnt_q;
  assign at    = $signed(CordW'(atan_q30(TableIdxW'(cnt_q))));
  assign sub_x = vect_q ? y_q[CordW-1] : !z_q[CordW-1];

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    vect_d = vect_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      x_d    = x_i;
      y_d    = y_i;
      z_d    = z_i;
      cnt_d  = '0;
      busy_d = 1'b1;
      vect_d = ctrl_i.vectoring;
    end else if (busy_q) begin
      if (sub_x) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - at;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + at;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == StepW'(NUM_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      vect_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      vect_q <= vect_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign x_o        = x_q;
  assign y_o        = y_q;
  assign z_o        = z_q;

endmodule

`default_nettype wire
